### sv/i64div_pkg.sv
// ----------------------------------------------------------------------------
// i64div_pkg: shared definitions for the 64-bit integer divider
// Holds the word width that the divider core and its checker default to.
// ----------------------------------------------------------------------------
package i64div_pkg;

    // Width of the dividend, divisor, quotient and remainder.
    localparam int DIV_WIDTH = 64;

endpackage

### sv/int64_signed_unsigned_divider_core.sv
// ----------------------------------------------------------------------------
// int64_signed_unsigned_divider_core: signed or unsigned integer divider
// Restoring shift-subtract division with a single shared subtractor, one
// quotient bit per clock, and sign handling before and after the loop.
// ----------------------------------------------------------------------------
// This core divides dividend_value by divisor_value and returns the quotient,
// truncated toward zero, and a remainder that carries the sign of the
// dividend, as in C. command selects unsigned (0) or signed two's complement
// (1) division. A transaction is accepted, with the operand magnitudes captured
// at acceptance, then forms its quotient bits in the loop through the shared
// subtractor, and then restores the signs into the output register in the
// fixup state, where it waits while that register still holds an untaken
// result. A zero divisor skips the loop and goes straight to the fixup state
// with an all-ones quotient, the dividend unchanged as remainder, and
// divide_by_zero set. The most negative value divided by minus one wraps to
// the most negative value with a zero remainder. The core holds one
// transaction at a time in its loop; in_ready is high whenever the loop is
// free, even while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module int64_signed_unsigned_divider_core
    import i64div_pkg::*;
#(
    parameter int DataWidth = DIV_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [DataWidth-1:0] dividend_value,
    input  logic [DataWidth-1:0] divisor_value,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DataWidth-1:0] quotient,
    output logic [DataWidth-1:0] remainder_value,
    output logic                 divide_by_zero
);

    localparam int CntW = $clog2(DataWidth);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FIXUP
    } state_t;

    state_t               state_reg;
    logic [CntW-1:0]      count_reg;
    // Partial remainder, and the dividend bits that shift out into it while
    // the quotient bits shift in from the bottom.
    logic [DataWidth-1:0] rem_reg;
    logic [DataWidth-1:0] quo_reg;
    logic [DataWidth-1:0] den_reg;
    logic                 q_neg_reg;
    logic                 r_neg_reg;
    logic                 dz_reg;
    logic                 out_valid_reg;
    logic [DataWidth-1:0] quotient_reg;
    logic [DataWidth-1:0] remainder_reg;
    logic                 dz_out_reg;

    logic                 accept;
    logic                 a_neg;
    logic                 b_neg;
    logic [DataWidth-1:0] a_mag;
    logic [DataWidth-1:0] b_mag;
    logic                 divisor_zero;
    logic [DataWidth:0]   shifted;
    logic [DataWidth:0]   diff;
    logic                 sub_ok;
    logic [DataWidth-1:0] rem_next;
    logic [DataWidth-1:0] quo_next;
    logic                 out_free;
    logic [DataWidth-1:0] q_final;
    logic [DataWidth-1:0] r_final;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Operand magnitudes, taken in the acceptance clock.
    assign a_neg        = command && dividend_value[DataWidth-1];
    assign b_neg        = command && divisor_value[DataWidth-1];
    assign a_mag        = a_neg ? (~dividend_value + 1'b1) : dividend_value;
    assign b_mag        = b_neg ? (~divisor_value + 1'b1) : divisor_value;
    assign divisor_zero = (divisor_value == '0);

    // The one trial subtraction of the loop. The partial remainder is always
    // below the divisor, so the shifted value is below twice the divisor and
    // a non-negative difference fits in DataWidth bits.
    assign shifted  = {rem_reg, quo_reg[DataWidth-1]};
    assign diff     = shifted - {1'b0, den_reg};
    assign sub_ok   = !diff[DataWidth];
    assign rem_next = sub_ok ? diff[DataWidth-1:0] : shifted[DataWidth-1:0];
    assign quo_next = {quo_reg[DataWidth-2:0], sub_ok};

    // Sign restoration on the way into the output register.
    assign out_free = !out_valid_reg || out_ready;
    assign q_final  = dz_reg ? '1 : (q_neg_reg ? (~quo_reg + 1'b1) : quo_reg);
    assign r_final  = dz_reg ? quo_reg : (r_neg_reg ? (~rem_reg + 1'b1) : rem_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            den_reg       <= '0;
            q_neg_reg     <= 1'b0;
            r_neg_reg     <= 1'b0;
            dz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            quotient_reg  <= '0;
            remainder_reg <= '0;
            dz_out_reg    <= 1'b0;
        end
        else
        begin
            // A new result is loaded in the fixup state once the output register is free;
            // otherwise a taken result empties the output register.
            if (state_reg == ST_FIXUP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= CntW'(DataWidth - 1);
                        rem_reg   <= '0;
                        dz_reg    <= divisor_zero;
                        if (divisor_zero)
                        begin
                            // Keep the dividend exactly as given.
                            quo_reg   <= dividend_value;
                            q_neg_reg <= 1'b0;
                            r_neg_reg <= 1'b0;
                            state_reg <= ST_FIXUP;
                        end
                        else
                        begin
                            quo_reg   <= a_mag;
                            den_reg   <= b_mag;
                            q_neg_reg <= a_neg ^ b_neg;
                            r_neg_reg <= a_neg;
                            state_reg <= ST_DIVIDE;
                        end
                    end
                end

                ST_DIVIDE:
                begin
                    rem_reg   <= rem_next;
                    quo_reg   <= quo_next;
                    count_reg <= count_reg - 1'b1;
                    if (count_reg == '0)
                    begin
                        state_reg <= ST_FIXUP;
                    end
                end

                ST_FIXUP:
                begin
                    if (out_free)
                    begin
                        quotient_reg  <= q_final;
                        remainder_reg <= r_final;
                        dz_out_reg    <= dz_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign quotient        = quotient_reg;
    assign remainder_value = remainder_reg;
    assign divide_by_zero  = dz_out_reg;

endmodule

### sv/i64div_checker.sv
// ----------------------------------------------------------------------------
// i64div_checker: port-level checks for the integer divider core
// Watches the handshakes and result fields, and is bound to the core below.
// ----------------------------------------------------------------------------
module i64div_checker
    import i64div_pkg::*;
#(
    parameter int DataWidth = DIV_WIDTH
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [DataWidth-1:0] quotient,
    input logic [DataWidth-1:0] remainder_value,
    input logic                 divide_by_zero
);

    // The loop holds one transaction, so it closes right after accepting.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("divider accepted while a transaction was in progress");

    // No result can appear in the clock right after an acceptance.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early after acceptance");

    // A zero divisor always reports an all-ones quotient.
    a_dz_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> quotient == '1)
        else $error("divide by zero without an all-ones quotient");

    // A stalled result holds its fields.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quotient)
            && $stable(remainder_value) && $stable(divide_by_zero))
        else $error("result changed while stalled");

endmodule

bind int64_signed_unsigned_divider_core i64div_checker #(
    .DataWidth (DataWidth)
) u_i64div_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .quotient        (quotient),
    .remainder_value (remainder_value),
    .divide_by_zero  (divide_by_zero)
);
